/* sv/awb_gain_from_ratios_core_macros.svh */
// Assertion macros for the white-balance gain core checker.
// Used by awb_chk; needs clk_i and rst_ni in the including scope.
`ifndef AWB_GAIN_FROM_RATIOS_CORE_MACROS_SVH
`define AWB_GAIN_FROM_RATIOS_CORE_MACROS_SVH

// same-cycle implication, reset masks the check
`define AWB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("awb check failed");

// next-cycle implication
`define AWB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("awb check failed");

`endif

/* sv/awb_pkg.sv */
// Shared constants and codes for the white-balance gain core.
// No dependencies.
package awb_pkg;

  localparam int unsigned UNITY_GAIN   = 256;
  localparam int unsigned UNITY_SHIFT  = 8;
  localparam int unsigned CFG_IDX_BITS = 8;

  localparam logic [CFG_IDX_BITS-1:0] REG_GOLDEN_RG = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GOLDEN_BG = 8'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_SAT     = 2'd3;

  // which channel the second divider produces
  typedef enum logic [1:0] {
    DSEL_NONE = 2'd0,
    DSEL_RED  = 2'd1,
    DSEL_BLUE = 2'd2
  } dsel_e;

endpackage

/* sv/awb_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Sideband bits travel with each transaction. Uses no package.
module awb_div #(
  parameter int unsigned NW = 18,
  parameter int unsigned DW = 10,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] sb_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] sb_o
);

  logic [NW-1:0] v_q;
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [SW-1:0] sb_q  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] quo_in;
    logic [NW-1:0] num_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] sb_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign sb_in  = sb_q[k-1];
    end

    assign trial = {rem_in, num_in[NW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_q[k] <= {quo_in[NW-2:0], ge};
        num_q[k] <= {num_in[NW-2:0], 1'b0};
        den_q[k] <= den_in;
        sb_q[k]  <= sb_in;
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_o   = quo_q[NW-1];
  assign sb_o    = sb_q[NW-1];

endmodule

/* sv/awb_gain_from_ratios_core.sv */
// White-balance gain calibration core: top level.
// Depends on awb_pkg and awb_div.
//
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid_i/in_stall_o  | red_ratio_i, blue_ratio_i, awb_valid_i
//  out     | source    | out_valid_o/out_stall_i| gain_*_o, write_*_o, status_o
//  cfg     | sink      | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One transaction accepted per cycle unless a stalled result holds the pipeline,
// one result per transaction. The pipeline holds RATIO_BITS+8 stages of
// the first divider pair, one multiply stage, 2*RATIO_BITS+8 stages of the
// second divider and the output register.
// Reset clears every valid bit; golden ratios reset to 300 and 250.
// A stalled result freezes the whole pipeline; a bubble at the output lets
// work move on even while out_stall_i is high.
module awb_gain_from_ratios_core #(
  parameter int unsigned RATIO_BITS = 10,
  parameter int unsigned GAIN_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [awb_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [RATIO_BITS-1:0]             cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [RATIO_BITS-1:0]             red_ratio_i,
  input  logic [RATIO_BITS-1:0]             blue_ratio_i,
  input  logic                              awb_valid_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [GAIN_BITS-1:0]              gain_red_o,
  output logic [GAIN_BITS-1:0]              gain_green_o,
  output logic [GAIN_BITS-1:0]              gain_blue_o,
  output logic                              write_red_o,
  output logic                              write_green_o,
  output logic                              write_blue_o,
  output logic [1:0]                        status_o
);

  localparam int unsigned RB  = RATIO_BITS;
  localparam int unsigned QW1 = RB + awb_pkg::UNITY_SHIFT;  // 256*ratio
  localparam int unsigned NW2 = QW1 + RB;                   // gain*ratio
  localparam int unsigned SW1 = 4 * RB + 4;
  localparam int unsigned SW2 = 3 * QW1 + 4;
  localparam logic [QW1-1:0] UNITY_Q = QW1'(awb_pkg::UNITY_GAIN);
  localparam logic [NW2-1:0] UNITY_W = NW2'(awb_pkg::UNITY_GAIN);
  localparam logic [NW2-1:0] GMAX    = NW2'((64'd1 << GAIN_BITS) - 64'd1);

  // golden ratio registers
  logic [RB-1:0] golden_rg_q, golden_bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      golden_rg_q <= RB'(300);
      golden_bg_q <= RB'(250);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        awb_pkg::REG_GOLDEN_RG: golden_rg_q <= cfg_data_i;
        awb_pkg::REG_GOLDEN_BG: golden_bg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // the whole pipeline moves unless a result sits stalled at the output
  logic out_v_q;
  logic en;
  assign en         = !out_v_q || !out_stall_i;
  assign in_stall_o = !en;

  // entry: branch choice, early status, dividend selection
  logic          b_lt, r_lt, zero;
  logic [1:0]    st_in;
  logic [QW1-1:0] num_x, num_y;
  logic [RB-1:0]  den_x, den_y;

  always_comb begin
    b_lt = blue_ratio_i < golden_bg_q;
    r_lt = red_ratio_i < golden_rg_q;
    zero = (red_ratio_i == '0) || (blue_ratio_i == '0) ||
           (golden_rg_q == '0) || (golden_bg_q == '0);
    if (!awb_valid_i) st_in = awb_pkg::ST_INVALID;
    else if (zero)    st_in = awb_pkg::ST_ZERO;
    else              st_in = awb_pkg::ST_OK;
    // both below golden: the two final gains directly; otherwise green candidates
    if (b_lt && r_lt) begin
      num_x = {golden_bg_q, 8'h00};
      den_x = blue_ratio_i;
      num_y = {golden_rg_q, 8'h00};
      den_y = red_ratio_i;
    end else begin
      num_x = {blue_ratio_i, 8'h00};
      den_x = golden_bg_q;
      num_y = {red_ratio_i, 8'h00};
      den_y = golden_rg_q;
    end
  end

  logic           v1;
  logic [QW1-1:0] quo_x, quo_y;
  logic [SW1-1:0] sb1;

  awb_div #(.NW(QW1), .DW(RB), .SW(SW1)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .num_i   (num_x),
    .den_i   (den_x),
    .sb_i    ({red_ratio_i, blue_ratio_i, golden_rg_q, golden_bg_q, st_in, b_lt, r_lt}),
    .valid_o (v1),
    .quo_o   (quo_x),
    .sb_o    (sb1)
  );

  awb_div #(.NW(QW1), .DW(RB), .SW(1)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .num_i   (num_y),
    .den_i   (den_y),
    .sb_i    (1'b0),
    .valid_o (),
    .quo_o   (quo_y),
    .sb_o    ()
  );

  // branch resolve and multiply for the second division
  logic [RB-1:0]  s1_mr, s1_mb, s1_gr, s1_gb;
  logic [1:0]     s1_st;
  logic           s1_blt, s1_rlt;
  logic [QW1-1:0] r0_d, g_d, b0_d;
  logic [RB-1:0]  gs_d, ms_d;
  awb_pkg::dsel_e dsel_d;

  assign {s1_mr, s1_mb, s1_gr, s1_gb, s1_st, s1_blt, s1_rlt} = sb1;

  always_comb begin
    r0_d   = UNITY_Q;
    g_d    = UNITY_Q;
    b0_d   = UNITY_Q;
    gs_d   = s1_gb;
    ms_d   = s1_mb;
    dsel_d = awb_pkg::DSEL_BLUE;
    case ({s1_blt, s1_rlt})
      2'b11: begin
        r0_d   = quo_y;
        b0_d   = quo_x;
        dsel_d = awb_pkg::DSEL_NONE;
      end
      2'b10: begin
        g_d = quo_y;
      end
      2'b01: begin
        g_d    = quo_x;
        gs_d   = s1_gr;
        ms_d   = s1_mr;
        dsel_d = awb_pkg::DSEL_RED;
      end
      default: begin
        if (quo_x > quo_y) begin
          g_d    = quo_x;
          gs_d   = s1_gr;
          ms_d   = s1_mr;
          dsel_d = awb_pkg::DSEL_RED;
        end else begin
          g_d = quo_y;
        end
      end
    endcase
  end

  logic           m_v_q;
  logic [NW2-1:0] prod_q;
  logic [RB-1:0]  ms_q;
  logic [QW1-1:0] r0_q, g_q, b0_q;
  logic [1:0]     m_st_q;
  awb_pkg::dsel_e dsel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= v1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= NW2'(g_d) * NW2'(gs_d);
      ms_q   <= ms_d;
      r0_q   <= r0_d;
      g_q    <= g_d;
      b0_q   <= b0_d;
      m_st_q <= s1_st;
      dsel_q <= dsel_d;
    end
  end

  logic           v2;
  logic [NW2-1:0] quo2;
  logic [SW2-1:0] sb2;

  awb_div #(.NW(NW2), .DW(RB), .SW(SW2)) u_div_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m_v_q),
    .num_i   (prod_q),
    .den_i   (ms_q),
    .sb_i    ({r0_q, g_q, b0_q, m_st_q, 2'(dsel_q)}),
    .valid_o (v2),
    .quo_o   (quo2),
    .sb_o    (sb2)
  );

  // finish: pick divider result, saturate, flags
  logic [QW1-1:0] f_r0, f_g, f_b0;
  logic [1:0]     f_st, f_dsel, st_d;
  logic [NW2-1:0] r_w, g_w, b_w, r_c, g_c, b_c;
  logic           sat, ok;

  assign {f_r0, f_g, f_b0, f_st, f_dsel} = sb2;

  always_comb begin
    r_w = (awb_pkg::dsel_e'(f_dsel) == awb_pkg::DSEL_RED)  ? quo2 : NW2'(f_r0);
    g_w = NW2'(f_g);
    b_w = (awb_pkg::dsel_e'(f_dsel) == awb_pkg::DSEL_BLUE) ? quo2 : NW2'(f_b0);
    sat = (r_w > GMAX) || (g_w > GMAX) || (b_w > GMAX);
    ok  = f_st == awb_pkg::ST_OK;
    if (!ok) begin
      r_c  = UNITY_W;
      g_c  = UNITY_W;
      b_c  = UNITY_W;
      st_d = f_st;
    end else begin
      r_c  = (r_w > GMAX) ? GMAX : r_w;
      g_c  = (g_w > GMAX) ? GMAX : g_w;
      b_c  = (b_w > GMAX) ? GMAX : b_w;
      st_d = sat ? awb_pkg::ST_SAT : awb_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gain_red_o    <= r_c[GAIN_BITS-1:0];
      gain_green_o  <= g_c[GAIN_BITS-1:0];
      gain_blue_o   <= b_c[GAIN_BITS-1:0];
      write_red_o   <= ok && (r_c > UNITY_W);
      write_green_o <= ok && (g_c > UNITY_W);
      write_blue_o  <= ok && (b_c > UNITY_W);
      status_o      <= st_d;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

/* sv/awb_chk.sv */
// Port-level checker for the white-balance gain core, bound to the top level.
// Depends on awb_pkg and awb_gain_from_ratios_core_macros.svh.
`include "awb_gain_from_ratios_core_macros.svh"

module awb_chk #(
  parameter int unsigned GAIN_BITS = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [GAIN_BITS-1:0] gain_red_o,
  input logic [GAIN_BITS-1:0] gain_green_o,
  input logic [GAIN_BITS-1:0] gain_blue_o,
  input logic                 write_red_o,
  input logic                 write_green_o,
  input logic                 write_blue_o,
  input logic [1:0]           status_o
);

  localparam logic [GAIN_BITS-1:0] UNITY = GAIN_BITS'(awb_pkg::UNITY_GAIN);

  `AWB_ASSERT_NXT(a_hold, out_valid_o && out_stall_i, out_valid_o)

  `AWB_ASSERT_IMP(a_err_nowrite, out_valid_o && (status_o == awb_pkg::ST_INVALID ||
    status_o == awb_pkg::ST_ZERO), !write_red_o && !write_green_o && !write_blue_o)

  `AWB_ASSERT_IMP(a_one_unity, out_valid_o && status_o == awb_pkg::ST_OK,
    gain_red_o == UNITY || gain_green_o == UNITY || gain_blue_o == UNITY)

  `AWB_ASSERT_IMP(a_not_all, out_valid_o, !(write_red_o && write_green_o && write_blue_o))

endmodule

bind awb_gain_from_ratios_core awb_chk #(.GAIN_BITS(GAIN_BITS)) u_awb_chk (.*);

/* tb/testbench.sv */
// Self-checking testbench for the white-balance gain calibration core.
// Depends on awb_pkg and awb_gain_from_ratios_core; no files or arguments.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RB = 10;
  localparam int GB = 16;
  localparam int LATENCY = 3 * RB + 18;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [GB-1:0] red;
    logic [GB-1:0] green;
    logic [GB-1:0] blue;
    logic          wr_red;
    logic          wr_green;
    logic          wr_blue;
    logic [1:0]    status;
  } gains_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [awb_pkg::CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [RB-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [RB-1:0] red_ratio_i = '0;
  logic [RB-1:0] blue_ratio_i = '0;
  logic awb_valid_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [GB-1:0] gain_red_o, gain_green_o, gain_blue_o;
  logic write_red_o, write_green_o, write_blue_o;
  logic [1:0] status_o;

  awb_gain_from_ratios_core #(.RATIO_BITS(RB), .GAIN_BITS(GB)) u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor's copy of the golden ratios
  logic [RB-1:0] golden_rg_q = 10'd300;
  logic [RB-1:0] golden_bg_q = 10'd250;

  gains_t expected_gains[$];
  int     n_fail = 0;
  int     n_results = 0;
  int     idle_cycles = 0;
  int     rx_wait = 0;       // receiver stall cycles still to serve
  int     rx_draw = 0;
  bit     hold_off = 1'b0;   // long receiver stall requested
  bit     rx_random = 1'b1;  // random receiver stalls enabled

  // Gain calculation: four branches on measured against golden ratios,
  // exact intermediates, only final gains saturated.
  function automatic gains_t calc_gains(logic [RB-1:0] mr, logic [RB-1:0] mb, logic ok);
    longint unsigned r, g, b, gr, gb, fb, fr, gmax;
    gains_t res;
    gr = golden_rg_q;
    gb = golden_bg_q;
    gmax = (64'd1 << GB) - 1;
    r = awb_pkg::UNITY_GAIN; g = awb_pkg::UNITY_GAIN; b = awb_pkg::UNITY_GAIN;
    res.status = awb_pkg::ST_OK;
    if (!ok) begin
      res.status = awb_pkg::ST_INVALID;
    end else if (mr == 0 || mb == 0 || gr == 0 || gb == 0) begin
      res.status = awb_pkg::ST_ZERO;
    end else begin
      if (mb < gb && mr < gr) begin
        b = awb_pkg::UNITY_GAIN * gb / mb;
        r = awb_pkg::UNITY_GAIN * gr / mr;
      end else if (mb < gb) begin
        g = awb_pkg::UNITY_GAIN * mr / gr;
        b = g * gb / mb;
      end else if (mr < gr) begin
        g = awb_pkg::UNITY_GAIN * mb / gb;
        r = g * gr / mr;
      end else begin
        fb = awb_pkg::UNITY_GAIN * mb / gb;
        fr = awb_pkg::UNITY_GAIN * mr / gr;
        if (fb > fr) begin
          g = fb;
          r = g * gr / mr;
        end else begin
          g = fr;
          b = g * gb / mb;
        end
      end
      if (r > gmax || g > gmax || b > gmax) res.status = awb_pkg::ST_SAT;
      if (r > gmax) r = gmax;
      if (g > gmax) g = gmax;
      if (b > gmax) b = gmax;
    end
    res.red = r[GB-1:0];
    res.green = g[GB-1:0];
    res.blue = b[GB-1:0];
    res.wr_red   = (res.status == awb_pkg::ST_OK || res.status == awb_pkg::ST_SAT) &&
                   r > awb_pkg::UNITY_GAIN;
    res.wr_green = (res.status == awb_pkg::ST_OK || res.status == awb_pkg::ST_SAT) &&
                   g > awb_pkg::UNITY_GAIN;
    res.wr_blue  = (res.status == awb_pkg::ST_OK || res.status == awb_pkg::ST_SAT) &&
                   b > awb_pkg::UNITY_GAIN;
    return res;
  endfunction

  // Send one calibration transaction, after a random gap if gap is set; predict on acceptance.
  // Valid drops only when a gap follows; drain() drops it at the end of a run.
  task automatic send_ratios(logic [RB-1:0] mr, logic [RB-1:0] mb, logic ok, bit gap = 1'b1);
    int wait_n;
    wait_n = gap ? $urandom_range(0, 10) : 0;
    if ($urandom_range(0, 3) == 0) wait_n = 0;  // bursts with no gaps
    if (wait_n != 0) begin
      in_valid_i <= 1'b0;
      repeat (wait_n) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    red_ratio_i  <= mr;
    blue_ratio_i <= mb;
    awb_valid_i  <= ok;
    do @(posedge clk_i); while (in_stall_o);
    expected_gains.push_back(calc_gains(mr, mb, ok));
  endtask

  // Wait until every expected result is back, then let the pipeline drain.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_gains.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_golden(logic [awb_pkg::CFG_IDX_BITS-1:0] idx, logic [RB-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == awb_pkg::REG_GOLDEN_RG) golden_rg_q = val;
    else if (idx == awb_pkg::REG_GOLDEN_BG) golden_bg_q = val;
    @(posedge clk_i);
  endtask

  // Receiver: after each result draws a random stall length in rx_draw, or a long hold-off.
  always @(posedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1'b1;
      rx_wait <= 0;
    end else if (!rx_random) begin
      out_stall_i <= 1'b0;
      rx_wait <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      rx_draw = $urandom_range(0, 10);
      rx_wait <= rx_draw;
      out_stall_i <= (rx_draw != 0);
    end else if (rx_wait > 1) begin
      rx_wait <= rx_wait - 1;
      out_stall_i <= 1'b1;
    end else begin
      rx_wait <= 0;
      out_stall_i <= 1'b0;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      gains_t exp_g;
      n_results++;
      if (expected_gains.size() == 0) begin
        $error("result with no expectation waiting");
        n_fail++;
      end else begin
        exp_g = expected_gains.pop_front();
        if (gain_red_o !== exp_g.red) begin
          $error("gain_red exp %0h got %0h", exp_g.red, gain_red_o); n_fail++;
        end
        if (gain_green_o !== exp_g.green) begin
          $error("gain_green exp %0h got %0h", exp_g.green, gain_green_o); n_fail++;
        end
        if (gain_blue_o !== exp_g.blue) begin
          $error("gain_blue exp %0h got %0h", exp_g.blue, gain_blue_o); n_fail++;
        end
        if (write_red_o !== exp_g.wr_red) begin
          $error("write_red exp %0b got %0b", exp_g.wr_red, write_red_o); n_fail++;
        end
        if (write_green_o !== exp_g.wr_green) begin
          $error("write_green exp %0b got %0b", exp_g.wr_green, write_green_o); n_fail++;
        end
        if (write_blue_o !== exp_g.wr_blue) begin
          $error("write_blue exp %0b got %0b", exp_g.wr_blue, write_blue_o); n_fail++;
        end
        if (status_o !== exp_g.status) begin
          $error("status exp %0d got %0d", exp_g.status, status_o); n_fail++;
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || hold_off)
      idle_cycles <= 0;
    else if (expected_gains.size() != 0 || in_valid_i) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [RB-1:0] rand_ratio();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 10'd1;
      default: return RB'($urandom_range(0, (1 << RB) - 1));
    endcase
  endfunction

  // Directed: extremes, each branch, invalid, zero and saturating cases.
  task automatic test_directed();
    send_ratios(10'd300, 10'd250, 1'b1);   // equal to golden
    send_ratios(10'd100, 10'd100, 1'b1);   // both below
    send_ratios(10'd600, 10'd100, 1'b1);   // blue below, red above
    send_ratios(10'd100, 10'd600, 1'b1);   // blue above, red below
    send_ratios(10'd900, 10'd400, 1'b1);   // both above, red dominant
    send_ratios(10'd400, 10'd900, 1'b1);   // both above, blue dominant
    send_ratios(10'd1,   10'd1,   1'b1);   // large gains
    send_ratios(10'd1,   10'd1023, 1'b1);  // saturation
    send_ratios(10'd1023, 10'd1,  1'b1);   // saturation
    send_ratios(10'd1023, 10'd1023, 1'b1);
    send_ratios(10'd0,   10'd200, 1'b1);   // zero ratio
    send_ratios(10'd200, 10'd0,   1'b1);
    send_ratios(10'd0,   10'd0,   1'b0);   // invalid beats zero
    send_ratios(10'd1023, 10'd1023, 1'b0); // invalid
    send_ratios(10'h2AA, 10'h155, 1'b1);
    send_ratios(10'h155, 10'h2AA, 1'b1);
    drain();
  endtask

  // Random items under one golden setting.
  task automatic test_random(int n);
    repeat (n) send_ratios(rand_ratio(), rand_ratio(), $urandom_range(0, 7) != 0);
    drain();
  endtask

  // Hold the receiver off while the sender keeps offering, so the core fills up.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (3 * LATENCY) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (LATENCY + 20) send_ratios(rand_ratio(), rand_ratio(), 1'b1, 1'b0);
    join
    drain();
    // sender pause with no receiver stalls, then back-to-back items
    rx_random = 1'b0;
    repeat (60) send_ratios(rand_ratio(), rand_ratio(), 1'b1, 1'b0);
    drain();
    rx_random = 1'b1;
  endtask

  // Walk through golden settings, extremes included; zero goldens too.
  task automatic test_golden_settings();
    logic [RB-1:0] rg_set[6] = '{10'd1, 10'd1023, 10'd512, 10'd0, 10'd77, 10'h2AA};
    logic [RB-1:0] bg_set[6] = '{10'd1023, 10'd1, 10'd0, 10'd512, 10'd901, 10'h155};
    for (int i = 0; i < 6; i++) begin
      write_golden(awb_pkg::REG_GOLDEN_RG, rg_set[i]);
      write_golden(awb_pkg::REG_GOLDEN_BG, bg_set[i]);
      // unused index
      write_golden(awb_pkg::CFG_IDX_BITS'(2 + i), RB'($urandom_range(0, 1023)));
      test_random(100);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(120);
    test_backpressure();
    test_golden_settings();
    $display("Ran %0d results: directed corners, random ratios, 6 golden settings,",
             n_results);
    $display("long output stall and sender pause.");
    if (n_fail == 0 && expected_gains.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
